FILE: hdl/kuf_pkg.sv
package kuf_pkg;

	localparam int VERTEX_W = 10;
	localparam int COUNT_W  = 11;
	localparam int WEIGHT_W = 64;

	localparam logic [COUNT_W-1:0] VCOUNT_RESET = 11'd1024;

	typedef logic [COUNT_W-1:0] vcount_t;

	typedef struct packed {
		logic                first_edge;
		logic [VERTEX_W-1:0] from_vertex;
		logic [VERTEX_W-1:0] to_vertex;
		logic [WEIGHT_W-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic                in_tree;
		logic [WEIGHT_W-1:0] tree_weight;
		logic                vertex_error;
	} result_t;

endpackage

FILE: hdl/kuf_stream_if.sv
interface kuf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/kuf_link_ram.sv
module kuf_link_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);
	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/kruskal_union_find_forest_core.sv
// Union-find core for Kruskal spanning forest construction.
// edge_in: one request per edge (first_edge, from_vertex, to_vertex, weight),
// edges presented in non-increasing weight order. result_out: one result per
// edge (in_tree, running tree_weight, vertex_error). cfg: writes vertex_count,
// always ready; write it only while the core is idle.
// One edge is processed at a time. Each root walk reads the parent memory once
// per hop (registered read), so the time from acceptance to result grows with
// the chain depths of both endpoints in the parent memory. After acceptance the
// core passes S_START, the from walk (S_FW), the to walk (S_TW) and S_FIN,
// where the result is registered; the next edge is taken back in S_IDLE.
// An edge with first_edge set first sweeps the whole parent memory back to
// singletons. An out-of-range endpoint skips the walks.
// After reset the same sweep runs with edge_in.ready low;
// vertex_count returns to 1024 and the sum to zero.
// The result sits in an output register; if the receiver stalls, the core
// holds the finished result and waits before its next result, while the
// next edge may already be accepted and walked.
module kruskal_union_find_forest_core #(
	parameter int VERTICES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	kuf_stream_if.sink   edge_in,
	kuf_stream_if.sink   cfg,
	kuf_stream_if.source result_out
);
	import kuf_pkg::*;

	localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int LW = (VW + 1 > COUNT_W) ? VW + 1 : COUNT_W;
	localparam logic [VW:0]   VMAX  = (VW + 1)'(VERTICES);
	localparam logic [LW-1:0] VLIM  = LW'(VERTICES);
	localparam logic [VW-1:0] VLAST = VW'(VERTICES - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_FW    = 3'd3;
	localparam logic [2:0] S_TW    = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic [VW-1:0]       cnt_q;
	logic [VW-1:0]       cur_q;
	logic [VW-1:0]       rf_q;
	logic [VW-1:0]       from_q;
	logic [VW-1:0]       to_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [WEIGHT_W-1:0] sum_q;
	logic                err_q;
	logic                joined_q;
	logic                item_q;
	vcount_t             vcount_q;
	logic                out_valid_q;
	result_t             out_q;

	logic [VW-1:0] rd_addr;
	logic [VW-1:0] rd_data;
	logic          ram_we;
	logic [VW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic          root;
	logic          accept;
	logic          out_free;
	logic [LW-1:0] vc_ext;
	logic [LW-1:0] limit;
	logic          range_err;

	kuf_link_ram #(.DEPTH(VERTICES), .AW(VW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign edge_in.ready   = (state_q == S_IDLE);
	assign accept          = edge_in.valid && edge_in.ready;
	assign cfg.ready       = 1'b1;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;
	assign out_free        = !out_valid_q || result_out.ready;

	assign vc_ext    = LW'(vcount_q);
	assign limit     = (vc_ext > VLIM) ? VLIM : vc_ext;
	assign range_err = (LW'(edge_in.data.from_vertex) >= limit) ||
	                   (LW'(edge_in.data.to_vertex) >= limit);

	assign root = (rd_data == cur_q) || ({1'b0, rd_data} >= VMAX);

	always_comb begin
		rd_addr   = cur_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = cnt_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_FW: begin
				rd_addr = root ? to_q : rd_data;
			end
			S_TW: begin
				rd_addr = rd_data;
				if (root && (rf_q != cur_q)) begin
					// link the to-root under the from-root
					ram_we    = 1'b1;
					ram_waddr = cur_q;
					ram_wdata = rf_q;
				end
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
			vcount_q    <= VCOUNT_RESET;
			sum_q       <= '0;
		end else begin
			if (cfg.valid) begin
				vcount_q <= cfg.data;
			end
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= 1'b1;
						cnt_q  <= '0;
						if (edge_in.data.first_edge) begin
							state_q <= S_CLEAR;
						end else if (range_err) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_CLEAR: begin
					sum_q <= '0;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == VLAST) begin
						if (!item_q) begin
							state_q <= S_IDLE;
						end else if (err_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_FW;
				end
				S_FW: begin
					if (root) begin
						state_q <= S_TW;
					end
				end
				S_TW: begin
					if (root) begin
						if (rf_q != cur_q) begin
							sum_q <= sum_q + w_q;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						item_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_q   <= VW'(edge_in.data.from_vertex);
			to_q     <= VW'(edge_in.data.to_vertex);
			cur_q    <= VW'(edge_in.data.from_vertex);
			w_q      <= edge_in.data.weight;
			err_q    <= range_err;
			joined_q <= 1'b0;
		end
		if (state_q == S_START) begin
			cur_q <= from_q;
		end
		if (state_q == S_FW) begin
			if (root) begin
				rf_q  <= cur_q;
				cur_q <= to_q;
			end else begin
				cur_q <= rd_data;
			end
		end
		if (state_q == S_TW) begin
			if (root) begin
				joined_q <= (rf_q != cur_q);
			end else begin
				cur_q <= rd_data;
			end
		end
		if ((state_q == S_FIN) && out_free) begin
			out_q.in_tree      <= joined_q;
			out_q.tree_weight  <= sum_q;
			out_q.vertex_error <= err_q;
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("edge accepted while idle state persisted");

	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == S_TW)) |-> (ram_wdata != ram_waddr))
		else $error("root linked to itself");

	a_err_not_joined: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> !(joined_q && err_q))
		else $error("rejected edge marked as joined");

	a_sum_on_join: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TW) && root && (rf_q != cur_q)) |=>
			(sum_q == $past(sum_q) + $past(w_q)))
		else $error("forest sum not updated on join");

	a_clear_walk_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !edge_in.ready)
		else $error("edge request taken during memory sweep");
endmodule

FILE: verif/kuf_forest_checker.sv
`timescale 1ns / 100ps

module kuf_forest_checker #(
	parameter int VERTICES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             edge_valid,
	input  logic             edge_ready,
	input  kuf_pkg::edge_t   edge_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  kuf_pkg::vcount_t cfg_data,
	input  logic             res_valid,
	input  logic             res_ready,
	input  kuf_pkg::result_t res_data,
	output int               outstanding,
	output int               fail_count
);
	import kuf_pkg::*;

	logic [VERTEX_W-1:0] link_mem [VERTICES];
	logic [WEIGHT_W-1:0] forest_total;
	vcount_t             active_count;
	result_t             pending_results[$];
	result_t             predicted;
	result_t             want;

	function automatic logic [VERTEX_W-1:0] walk_to_root(logic [VERTEX_W-1:0] v);
		logic [VERTEX_W-1:0] node;
		node = v;
		for (int steps = 0; steps < VERTICES; steps++) begin
			if (link_mem[node] == node)
				break;
			node = link_mem[node];
		end
		return node;
	endfunction

	// updates the forest copy and returns what the core should report
	function automatic result_t join_edge(edge_t e);
		result_t             r;
		int                  lim;
		logic [VERTEX_W-1:0] root_from;
		logic [VERTEX_W-1:0] root_to;
		lim = (active_count > VERTICES) ? VERTICES : int'(active_count);
		if (e.first_edge) begin
			for (int i = 0; i < VERTICES; i++)
				link_mem[i] = VERTEX_W'(i);
			forest_total = '0;
		end
		r.in_tree      = 1'b0;
		r.vertex_error = 1'b0;
		if (e.from_vertex >= lim || e.to_vertex >= lim) begin
			r.vertex_error = 1'b1;
		end else begin
			root_from = walk_to_root(e.from_vertex);
			root_to   = walk_to_root(e.to_vertex);
			if (root_from != root_to) begin
				link_mem[root_to] = root_from;
				forest_total      = forest_total + e.weight;
				r.in_tree         = 1'b1;
			end
		end
		r.tree_weight = forest_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VERTICES; i++)
				link_mem[i] = VERTEX_W'(i);
			forest_total = '0;
			active_count = VCOUNT_RESET;
			pending_results.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				active_count = cfg_data;
			if (edge_valid && edge_ready) begin
				predicted       = join_edge(edge_data);
				pending_results = {pending_results, predicted};
			end
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					$error("result with no pending request: tree_weight %0h",
						res_data.tree_weight);
				end else begin
					want = pending_results.pop_front();
					if (res_data.in_tree !== want.in_tree) begin
						fail_count++;
						$error("in_tree: expected %0d, got %0d", want.in_tree, res_data.in_tree);
					end
					if (res_data.tree_weight !== want.tree_weight) begin
						fail_count++;
						$error("tree_weight: expected %0h, got %0h",
							want.tree_weight, res_data.tree_weight);
					end
					if (res_data.vertex_error !== want.vertex_error) begin
						fail_count++;
						$error("vertex_error: expected %0d, got %0d",
							want.vertex_error, res_data.vertex_error);
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import kuf_pkg::*;

	localparam int VERTICES    = 1024;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;
	localparam int PHASES      = 13;
	localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = '1;

	typedef enum int {SHAPE_RANDOM, SHAPE_CHAIN, SHAPE_STAR} shape_t;

	logic clk;
	logic arst_n;

	kuf_stream_if #(.T(edge_t))   edge_if ();
	kuf_stream_if #(.T(vcount_t)) cfg_if ();
	kuf_stream_if #(.T(result_t)) res_if ();

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit rx_hold_req  = 1'b0;
	int cur_count    = 1024;
	int items_sent   = 0;
	int cycle_cnt;
	int outstanding;
	int fail_count;

	int phase_counts [PHASES] = '{16, 1024, 8, 2, 64, 1, 1024, 0, 2047, 33, 1025, 512, 3};

	kruskal_union_find_forest_core #(.VERTICES(VERTICES)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_in    (edge_if),
		.cfg        (cfg_if),
		.result_out (res_if)
	);

	kuf_forest_checker #(.VERTICES(VERTICES)) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_valid  (edge_if.valid),
		.edge_ready  (edge_if.ready),
		.edge_data   (edge_if.data),
		.cfg_valid   (cfg_if.valid),
		.cfg_ready   (cfg_if.ready),
		.cfg_data    (cfg_if.data),
		.res_valid   (res_if.valid),
		.res_ready   (res_if.ready),
		.res_data    (res_if.data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, or a long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic int count_limit();
		return (cur_count > VERTICES) ? VERTICES : cur_count;
	endfunction

	function automatic edge_t make_edge(bit first, int from_v, int to_v,
		logic [WEIGHT_W-1:0] w);
		edge_t e;
		e.first_edge  = first;
		e.from_vertex = VERTEX_W'(from_v);
		e.to_vertex   = VERTEX_W'(to_v);
		e.weight      = w;
		return e;
	endfunction

	// mostly in range, a few past the limit where the limit allows it
	function automatic int pick_vertex();
		int lim;
		lim = count_limit();
		if (lim == 0 || (lim < 1024 && $urandom_range(99) < 6))
			return $urandom_range(1023, lim);
		return $urandom_range(lim - 1);
	endfunction

	task automatic send_edge(input edge_t e);
		while ($urandom_range(99) < tx_idle_pct) begin
			edge_if.valid <= 1'b0;
			@(posedge clk);
		end
		edge_if.valid <= 1'b1;
		edge_if.data  <= e;
		@(posedge clk);
		while (!edge_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_count(input int v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= vcount_t'(v);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		cur_count = v;
	endtask

	task automatic drain();
		edge_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
			default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
		endcase
	endtask

	// one graph's edges in non-increasing weight order
	task automatic send_forest(input int n_edges, input bit fresh, input shape_t shape);
		logic [WEIGHT_W-1:0] w;
		logic [WEIGHT_W-1:0] step;
		int                  lim;
		int                  base;
		int                  from_v;
		int                  to_v;
		lim  = (count_limit() < 1) ? 1 : count_limit();
		base = $urandom_range(lim - 1);
		w    = ($urandom_range(3) == 0) ? MAX_WEIGHT - WEIGHT_W'($urandom_range(1000)) :
			{$urandom, $urandom};
		for (int i = 0; i < n_edges; i++) begin
			case (shape)
				// base sinks one level per edge, so its root walk keeps growing
				SHAPE_CHAIN: begin from_v = (base + i + 1) % lim; to_v = base; end
				SHAPE_STAR:  begin from_v = base; to_v = (base + i + 1) % lim; end
				default:     begin from_v = pick_vertex(); to_v = pick_vertex(); end
			endcase
			if (count_limit() == 0) begin
				from_v = pick_vertex();
				to_v   = pick_vertex();
			end
			send_edge(make_edge(fresh && i == 0, from_v, to_v, w));
			case ($urandom_range(3))
				0: step = '0;
				1: step = WEIGHT_W'($urandom_range(255));
				2: step = {32'b0, $urandom};
				default: step = {$urandom, $urandom};
			endcase
			w = (step > w) ? '0 : w - step;
		end
	endtask

	task automatic send_noise();
		send_edge(make_edge(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
			{$urandom, $urandom}));
	endtask

	initial begin
		int     budget;
		int     start;
		int     pick;
		int     n_edges;
		int     lim;
		bit     paused;
		shape_t shape;

		edge_if.valid <= 1'b0;
		edge_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		arst_n        <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset count: full vertex range, sum wraps past the top
		send_edge(make_edge(1, 0, 1, MAX_WEIGHT));
		send_edge(make_edge(0, 1023, 0, MAX_WEIGHT));
		send_edge(make_edge(0, 1, 1023, 64'd1));
		send_edge(make_edge(0, 5, 5, 64'd1));
		send_edge(make_edge(0, 682, 341, 64'd0));
		send_edge(make_edge(0, 341, 1023, 64'd0));

		// zero count: every edge rejected, first_edge still clears
		drain();
		write_count(0);
		send_edge(make_edge(0, 0, 0, 64'd5));
		send_edge(make_edge(1, 3, 4, 64'd9));

		drain();
		write_count(1);
		send_edge(make_edge(0, 0, 0, 64'd7));
		send_edge(make_edge(0, 0, 1, 64'd7));
		send_edge(make_edge(0, 1, 0, 64'd7));

		drain();
		write_count(2);
		send_edge(make_edge(0, 0, 1, MAX_WEIGHT));
		send_edge(make_edge(0, 1, 0, 64'd3));
		send_edge(make_edge(1, 0, 5, 64'd1));
		send_edge(make_edge(0, 1, 0, 64'd4));

		// counts above the vertex range saturate
		drain();
		write_count(2047);
		send_edge(make_edge(0, 1023, 1022, 64'hFFFF_0000_FFFF_0000));
		send_edge(make_edge(0, 0, 1023, 64'h0000_FFFF_0000_FFFF));
		drain();
		write_count(1025);
		send_edge(make_edge(0, 1023, 0, 64'd2));
		send_edge(make_edge(0, 512, 1023, 64'd1));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_count((p == PHASES - 1) ? $urandom_range(2047) : phase_counts[p]);
			set_idling(p % 4);
			// core fills and stalls its input while results are held back
			if (p % 4 == 0)
				rx_hold_req = 1'b1;
			lim    = count_limit();
			budget = (lim == 0) ? 30 : 100;
			start  = items_sent;
			paused = 1'b0;
			while (items_sent - start < budget) begin
				if (!paused && items_sent - start >= budget / 2) begin
					drain();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 60)
					shape = SHAPE_RANDOM;
				else if (pick < 80)
					shape = SHAPE_CHAIN;
				else
					shape = SHAPE_STAR;
				if (lim <= 16)
					n_edges = $urandom_range(2 * lim + 2, 1);
				else if (lim >= 512 && shape == SHAPE_CHAIN && $urandom_range(9) == 0)
					n_edges = $urandom_range(150, 60);
				else
					n_edges = $urandom_range(30, 2);
				pick = $urandom_range(99);
				if (pick < 70)
					send_forest(n_edges, 1'b1, shape);
				else if (pick < 85)
					send_forest(n_edges, 1'b0, shape);
				else
					repeat ($urandom_range(3, 1)) send_noise();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: kruskal_union_find_forest_core.f
hdl/kuf_pkg.sv
hdl/kuf_stream_if.sv
hdl/kuf_link_ram.sv
hdl/kruskal_union_find_forest_core.sv
verif/kuf_forest_checker.sv
verif/tb_top.sv
